>>> rtl/ccc_pkg.sv
// Constants and types shared by the circle contact pipeline.
`default_nettype none
package ccc_pkg;

  localparam int NORM_FRAC  = 14;                  // fraction bits of the normal
  localparam int SQRT_STEPS = 32;                  // one root bit per stage
  localparam int REM_W      = 35;                  // square root partial remainder
  localparam int QUOT_W     = NORM_FRAC + 1;       // normal magnitude bits
  localparam int NUM_W      = 32 + NORM_FRAC + 1;  // rounded dividend
  localparam int NRM_W      = 16;
  localparam int H_W        = 34;
  localparam int PROD_W     = NRM_W + H_W;
  localparam int OFF_W      = PROD_W - QUOT_W;
  localparam int PX_W       = OFF_W + 1;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        ra;
    logic [15:0]        ida;
    logic [15:0]        idb;
    logic               dxneg;
    logic               dyneg;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        m;
    logic               hit;
  } ctx_t;

endpackage
`default_nettype wire

>>> rtl/circle_circle_contact.sv
// Circle against circle contact test, fully pipelined.
//
//  port group      dir  handshake           word
//  --------------  ---  ------------------  ------------------------------------
//  command         in   start_i / busy_o    two centres, radii and entity ids
//  result          out  valid_o strobe      hit, ids, contact, normal, depth
//
// One word is taken every cycle; busy_o stays low. Each word passes through
// the input register, difference, squares and compare, 32 square root stages
// (one root bit each), 15 divider stages (one normal bit each, both axes side
// by side), then multiply, round and output. Reset clears only the valid
// bits. The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module circle_circle_contact (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] first_x_i,
  input  wire logic [31:0] first_y_i,
  input  wire logic [30:0] first_radius_i,
  input  wire logic [15:0] first_entity_i,
  input  wire logic [31:0] second_x_i,
  input  wire logic [31:0] second_y_i,
  input  wire logic [30:0] second_radius_i,
  input  wire logic [15:0] second_entity_i,
  output logic             valid_o,
  output logic             hit_o,
  output logic [15:0]      first_id_out_o,
  output logic [15:0]      second_id_out_o,
  output logic [31:0]      contact_x_o,
  output logic [31:0]      contact_y_o,
  output logic [15:0]      normal_x_o,
  output logic [15:0]      normal_y_o,
  output logic [30:0]      penetration_o
);
  import ccc_pkg::*;

  assign busy_o = 1'b0;

  // ---------------- input register
  logic        v0_q;
  logic [31:0] ax0_q, ay0_q, bx0_q, by0_q;
  logic [30:0] ra0_q, rb0_q;
  logic [15:0] ida0_q, idb0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax0_q  <= first_x_i;
      ay0_q  <= first_y_i;
      ra0_q  <= first_radius_i;
      ida0_q <= first_entity_i;
      bx0_q  <= second_x_i;
      by0_q  <= second_y_i;
      rb0_q  <= second_radius_i;
      idb0_q <= second_entity_i;
    end
  end

  // ---------------- differences, radius sum, coarse reject
  logic [32:0] dx1, dy1, adx1, ady1;
  logic [31:0] m1;
  ctx_t        c1_d, c1_q;
  logic        v1_q;

  always_comb begin
    dx1  = {bx0_q[31], bx0_q} - {ax0_q[31], ax0_q};
    dy1  = {by0_q[31], by0_q} - {ay0_q[31], ay0_q};
    adx1 = dx1[32] ? (33'd0 - dx1) : dx1;
    ady1 = dy1[32] ? (33'd0 - dy1) : dy1;
    m1   = {1'b0, ra0_q} + {1'b0, rb0_q};
    c1_d.ax    = ax0_q;
    c1_d.ay    = ay0_q;
    c1_d.ra    = ra0_q;
    c1_d.ida   = ida0_q;
    c1_d.idb   = idb0_q;
    c1_d.dxneg = dx1[32];
    c1_d.dyneg = dy1[32];
    c1_d.adx   = adx1[31:0];
    c1_d.ady   = ady1[31:0];
    c1_d.m     = m1;
    c1_d.hit   = (adx1 < {1'b0, m1}) && (ady1 < {1'b0, m1});
  end

  // ---------------- squares
  logic [63:0] sqx2_q, sqy2_q, msq2_q;
  ctx_t        c2_q;
  logic        v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= c1_d;
    c2_q   <= c1_q;
    sqx2_q <= c1_q.adx * c1_q.adx;
    sqy2_q <= c1_q.ady * c1_q.ady;
    msq2_q <= c1_q.m * c1_q.m;
  end

  // ---------------- exact overlap compare, square root set-up
  logic [64:0] dsq3;
  ctx_t        c3;

  always_comb begin
    dsq3   = {1'b0, sqx2_q} + {1'b0, sqy2_q};
    c3     = c2_q;
    c3.hit = c2_q.hit && (dsq3 < {1'b0, msq2_q});
  end

  logic             sq_v_q    [0:SQRT_STEPS];
  logic [REM_W-1:0] sq_rem_q  [0:SQRT_STEPS];
  logic [31:0]      sq_root_q [0:SQRT_STEPS];
  logic [63:0]      sq_val_q  [0:SQRT_STEPS];
  ctx_t             sq_c_q    [0:SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else         sq_v_q[0] <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_val_q[0]  <= dsq3[63:0];
    sq_c_q[0]    <= c3;
  end

  // ---------------- square root, one bit a stage
  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem2, trial;
    logic             ge;

    assign rem2  = {sq_rem_q[k-1][REM_W-3:0], sq_val_q[k-1][63:62]};
    assign trial = {1'b0, sq_root_q[k-1], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else         sq_v_q[k] <= sq_v_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[k]  <= ge ? (rem2 - trial) : rem2;
      sq_root_q[k] <= {sq_root_q[k-1][30:0], ge};
      sq_val_q[k]  <= {sq_val_q[k-1][61:0], 2'b00};
      sq_c_q[k]    <= sq_c_q[k-1];
    end
  end

  // ---------------- divider set-up: dividend carries the rounding half
  logic [31:0]      dist_s, depth_s;
  logic [NUM_W-1:0] numx_s, numy_s;

  always_comb begin
    dist_s  = sq_root_q[SQRT_STEPS];
    depth_s = sq_c_q[SQRT_STEPS].m - dist_s;
    numx_s  = {1'b0, sq_c_q[SQRT_STEPS].adx, NORM_FRAC'(0)} + NUM_W'(dist_s >> 1);
    numy_s  = {1'b0, sq_c_q[SQRT_STEPS].ady, NORM_FRAC'(0)} + NUM_W'(dist_s >> 1);
  end

  logic              dv_v_q     [0:QUOT_W];
  logic [31:0]       dv_rx_q    [0:QUOT_W];
  logic [31:0]       dv_ry_q    [0:QUOT_W];
  logic [QUOT_W-1:0] dv_lx_q    [0:QUOT_W];
  logic [QUOT_W-1:0] dv_ly_q    [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qx_q    [0:QUOT_W];
  logic [QUOT_W-1:0] dv_qy_q    [0:QUOT_W];
  logic [31:0]       dv_dist_q  [0:QUOT_W];
  logic [31:0]       dv_depth_q [0:QUOT_W];
  ctx_t              dv_c_q     [0:QUOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= sq_v_q[SQRT_STEPS];
  end

  always_ff @(posedge clk_i) begin
    dv_rx_q[0]    <= numx_s[NUM_W-1:QUOT_W];
    dv_ry_q[0]    <= numy_s[NUM_W-1:QUOT_W];
    dv_lx_q[0]    <= numx_s[QUOT_W-1:0];
    dv_ly_q[0]    <= numy_s[QUOT_W-1:0];
    dv_qx_q[0]    <= '0;
    dv_qy_q[0]    <= '0;
    dv_dist_q[0]  <= dist_s;
    dv_depth_q[0] <= depth_s;
    dv_c_q[0]     <= sq_c_q[SQRT_STEPS];
  end

  // ---------------- restoring divide, one quotient bit a stage, both axes
  for (genvar k = 1; k <= QUOT_W; k++) begin : g_div
    logic [32:0] rx2, ry2, den;
    logic        gex, gey;

    assign den = {1'b0, dv_dist_q[k-1]};
    assign rx2 = {dv_rx_q[k-1], dv_lx_q[k-1][QUOT_W-1]};
    assign ry2 = {dv_ry_q[k-1], dv_ly_q[k-1][QUOT_W-1]};
    assign gex = rx2 >= den;
    assign gey = ry2 >= den;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else         dv_v_q[k] <= dv_v_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      dv_rx_q[k]    <= gex ? 32'(rx2 - den) : rx2[31:0];
      dv_ry_q[k]    <= gey ? 32'(ry2 - den) : ry2[31:0];
      dv_lx_q[k]    <= dv_lx_q[k-1] << 1;
      dv_ly_q[k]    <= dv_ly_q[k-1] << 1;
      dv_qx_q[k]    <= {dv_qx_q[k-1][QUOT_W-2:0], gex};
      dv_qy_q[k]    <= {dv_qy_q[k-1][QUOT_W-2:0], gey};
      dv_dist_q[k]  <= dv_dist_q[k-1];
      dv_depth_q[k] <= dv_depth_q[k-1];
      dv_c_q[k]     <= dv_c_q[k-1];
    end
  end

  // ---------------- signed normal and contact lever
  logic [NRM_W-1:0]        nmx_e, nmy_e;
  logic signed [NRM_W-1:0] nx_e, ny_e;
  logic signed [H_W-1:0]   h_e;
  logic                    ve_q;
  logic signed [NRM_W-1:0] nx_q, ny_q;
  logic signed [H_W-1:0]   h_q;
  logic [31:0]             depth_e_q;
  ctx_t                    ce_q;

  always_comb begin
    nmx_e = NRM_W'(dv_qx_q[QUOT_W]);
    nmy_e = NRM_W'(dv_qy_q[QUOT_W]);
    if (dv_dist_q[QUOT_W] == '0) begin
      // coincident centres: point along +x
      nx_e = NRM_W'(1 << NORM_FRAC);
      ny_e = '0;
    end else begin
      nx_e = dv_c_q[QUOT_W].dxneg ? -$signed(nmx_e) : $signed(nmx_e);
      ny_e = dv_c_q[QUOT_W].dyneg ? -$signed(nmy_e) : $signed(nmy_e);
    end
    h_e = $signed({2'b00, dv_c_q[QUOT_W].ra, 1'b0}) - $signed({2'b00, dv_depth_q[QUOT_W]});
  end

  // ---------------- products
  logic                     vf_q;
  logic signed [PROD_W-1:0] px_prod_q, py_prod_q;
  logic [31:0]              depth_f_q;
  ctx_t                     cf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      ve_q <= dv_v_q[QUOT_W];
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q      <= nx_e;
    ny_q      <= ny_e;
    h_q       <= h_e;
    depth_e_q <= dv_depth_q[QUOT_W];
    ce_q      <= dv_c_q[QUOT_W];
    px_prod_q <= PROD_W'(nx_q) * PROD_W'(h_q);
    py_prod_q <= PROD_W'(ny_q) * PROD_W'(h_q);
    depth_f_q <= depth_e_q;
    cf_q      <= ce_q;
  end

  // normal copies for the last stage
  logic signed [NRM_W-1:0] nxf_q, nyf_q;

  always_ff @(posedge clk_i) begin
    nxf_q <= nx_q;
    nyf_q <= ny_q;
  end

  // ---------------- round half away from zero, add, saturate
  // negative products take one less than the half, so a plain arithmetic
  // shift rounds ties away from zero without taking the magnitude
  function automatic logic [31:0] place(input logic signed [PROD_W-1:0] prod,
                                        input logic signed [31:0]       base);
    logic signed [PROD_W-1:0] rnd;
    logic signed [PX_W-1:0]   off, sum;
    rnd = prod + (prod[PROD_W-1] ? PROD_W'((1 << NORM_FRAC) - 1)
                                 : PROD_W'(1 << NORM_FRAC));
    off = PX_W'(rnd >>> QUOT_W);
    sum = PX_W'(base) + off;
    if (sum > $signed(PX_W'(32'h7fff_ffff)))       place = 32'h7fff_ffff;
    else if (sum < -$signed(PX_W'(33'h0_8000_0000))) place = 32'h8000_0000;
    else                                              place = sum[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= vf_q;
  end

  always_ff @(posedge clk_i) begin
    hit_o <= cf_q.hit;
    if (cf_q.hit) begin
      first_id_out_o  <= cf_q.ida;
      second_id_out_o <= cf_q.idb;
      contact_x_o     <= place(px_prod_q, cf_q.ax);
      contact_y_o     <= place(py_prod_q, cf_q.ay);
      normal_x_o      <= nxf_q;
      normal_y_o      <= nyf_q;
      penetration_o   <= depth_f_q[31] ? 31'h7fff_ffff : depth_f_q[30:0];
    end else begin
      first_id_out_o  <= '0;
      second_id_out_o <= '0;
      contact_x_o     <= '0;
      contact_y_o     <= '0;
      normal_x_o      <= '0;
      normal_y_o      <= '0;
      penetration_o   <= '0;
    end
  end

`ifndef SYNTH
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> penetration_o == '0 && normal_x_o == '0 && contact_x_o == '0)
    else $error("miss word carries non-zero fields");

  a_hit_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> penetration_o != '0)
    else $error("overlap with zero depth");

  a_norm_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_o |-> $signed(normal_x_o) <= 16'sd16384 && $signed(normal_x_o) >= -16'sd16384
                     && $signed(normal_y_o) <= 16'sd16384 && $signed(normal_y_o) >= -16'sd16384)
    else $error("normal out of unit range");
`endif

endmodule
`default_nettype wire

>>> bench/circle_circle_contact_tb.sv
// Self-checking testbench for the circle against circle contact pipeline.
`timescale 1ns / 1ps
`default_nettype none
module circle_circle_contact_tb;

  typedef struct packed {
    logic        hit;
    logic [15:0] ida;
    logic [15:0] idb;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [30:0] depth;
  } contact_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] first_x_i = '0, first_y_i = '0, second_x_i = '0, second_y_i = '0;
  logic [30:0] first_radius_i = '0, second_radius_i = '0;
  logic [15:0] first_entity_i = '0, second_entity_i = '0;
  logic        valid_o, hit_o;
  logic [15:0] first_id_out_o, second_id_out_o, normal_x_o, normal_y_o;
  logic [31:0] contact_x_o, contact_y_o;
  logic [30:0] penetration_o;

  contact_t    contact_q[$];
  int          errors = 0;
  int          sent = 0;
  int          hits = 0;
  longint      cycles = 0;

  localparam longint CYCLE_LIMIT = 200000;

  circle_circle_contact u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("circle_circle_contact regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic contact_t predict_contact(
      logic [31:0] ax_w, ay_w, logic [30:0] ra, logic [15:0] ida,
      logic [31:0] bx_w, by_w, logic [30:0] rb, logic [15:0] idb);
    contact_t        c;
    longint          ax, ay, dx, dy, nx, ny, h;
    longint unsigned adx, ady, m, msq, dsq, dlen, depth;
    c = '0;
    ax = longint'(signed'(ax_w));
    ay = longint'(signed'(ay_w));
    dx = longint'(signed'(bx_w)) - ax;
    dy = longint'(signed'(by_w)) - ay;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    m = longint'(ra) + longint'(rb);
    if (adx >= m || ady >= m) return c;
    msq = m * m;
    if (adx * adx >= msq - ady * ady) return c;
    dsq = adx * adx + ady * ady;
    dlen = isqrt(dsq);
    depth = m - dlen;
    if (dlen == 0) begin
      nx = 64'sd1 << 14;
      ny = 0;
    end else begin
      nx = round_div(dx * 16384, dlen);
      ny = round_div(dy * 16384, dlen);
    end
    h = 2 * longint'(ra) - longint'(depth);
    c.hit = 1'b1;
    c.ida = ida;
    c.idb = idb;
    c.cx = sat32(ax + round_div(nx * h, 64'd32768));
    c.cy = sat32(ay + round_div(ny * h, 64'd32768));
    c.nx = nx[15:0];
    c.ny = ny[15:0];
    c.depth = (depth > 64'h7fffffff) ? 31'h7fffffff : depth[30:0];
    return c;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && valid_o) begin
      if (contact_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = contact_q.pop_front();
        if (hit_o !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, hit_o); errors++;
        end
        if (first_id_out_o !== e.ida) begin
          $error("first_id_out exp %0h got %0h", e.ida, first_id_out_o); errors++;
        end
        if (second_id_out_o !== e.idb) begin
          $error("second_id_out exp %0h got %0h", e.idb, second_id_out_o); errors++;
        end
        if (contact_x_o !== e.cx) begin
          $error("contact_x exp %0h got %0h", e.cx, contact_x_o); errors++;
        end
        if (contact_y_o !== e.cy) begin
          $error("contact_y exp %0h got %0h", e.cy, contact_y_o); errors++;
        end
        if (normal_x_o !== e.nx) begin
          $error("normal_x exp %0h got %0h", e.nx, normal_x_o); errors++;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y exp %0h got %0h", e.ny, normal_y_o); errors++;
        end
        if (penetration_o !== e.depth) begin
          $error("penetration exp %0h got %0h", e.depth, penetration_o); errors++;
        end
        if (e.hit) hits++;
      end
    end
  end

  // random gap first, then drive one word and hold start until accepted;
  // called and returns at a falling edge
  task automatic send_pair(logic [31:0] ax, ay, logic [30:0] ra, logic [15:0] ida,
                           logic [31:0] bx, by, logic [30:0] rb, logic [15:0] idb,
                           bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(8) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    first_x_i <= ax; first_y_i <= ay; first_radius_i <= ra; first_entity_i <= ida;
    second_x_i <= bx; second_y_i <= by; second_radius_i <= rb; second_entity_i <= idb;
    do @(posedge clk_i); while (busy_o);
    contact_q.push_back(predict_contact(ax, ay, ra, ida, bx, by, rb, idb));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_pair(0, 0, 31'h10000, 16'h0001, 32'h8000, 0, 31'h10000, 16'h0002);
    // coincident centres
    send_pair(32'h1234, 32'h5678, 31'h100, 16'hffff, 32'h1234, 32'h5678, 31'h1, 16'h0);
    // touching, no overlap
    send_pair(0, 0, 31'h10000, 1, 32'h20000, 0, 31'h10000, 2);
    // zero radius sum
    send_pair(5, 5, 0, 3, 5, 5, 0, 4);
    // extreme radii, centres at both ends
    send_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 16'hffff,
              32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 16'hffff);
    send_pair(32'h7fffffff, 32'h80000000, 31'h7fffffff, 16'haaaa,
              32'h80000000, 32'h7fffffff, 31'h7fffffff, 16'h5555);
    send_pair(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 7,
              32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 8);
    send_pair(32'h80000000, 0, 31'h7fffffff, 9, 32'h80000000, 0, 31'h7fffffff, 10);
    // negative directions along each axis and diagonal, then small positive offsets
    send_pair(0, 0, 31'h30000, 11, 32'hffff0000, 0, 31'h10000, 12);
    send_pair(0, 0, 31'h30000, 13, 0, 32'hffff0000, 31'h10000, 14);
    send_pair(0, 0, 31'h30000, 15, 32'hfffe0000, 32'hfffe0000, 31'h30000, 16);
    send_pair(0, 0, 31'h1, 17, 32'h1, 32'h1, 31'h1, 18);
    send_pair(0, 0, 0, 19, 1, 0, 31'h2, 20);
  endtask

  task automatic test_random(int n, bit gaps);
    logic [31:0] ax, ay, bx, by;
    logic [30:0] ra, rb;
    int          sh;
    repeat (n) begin
      sh = $urandom_range(30);
      ax = $urandom; ay = $urandom;
      ra = 31'($urandom >> (1 + $urandom_range(30)));
      rb = 31'($urandom >> (1 + $urandom_range(30)));
      case ($urandom_range(3))
        0: begin bx = $urandom; by = $urandom; end
        default: begin
          // near neighbours, mostly overlapping
          bx = ax + (signed'($urandom) >>> (1 + sh));
          by = ay + (signed'($urandom) >>> (1 + sh));
          ra = 31'(($urandom >> (1 + sh)) + 1);
          rb = 31'($urandom >> (1 + sh));
        end
      endcase
      send_pair(ax, ay, ra, 16'($urandom), bx, by, rb, 16'($urandom), gaps);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(550, 1'b1);
    test_random(200, 1'b0);   // back to back words
    drain();
    $display("sent %0d pairs, %0d overlaps checked, the rest misses", sent, hits);
    if (errors == 0) $display("circle_circle_contact regression: pass");
    else $display("circle_circle_contact regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
